FILE: src/efs_pkg.sv
// Shared constants, register index codes and types for the effort frame scorer.
package efs_pkg;

   localparam int FRAC_BITS_DEF   = 12;
   localparam int OFFSET_BITS_DEF = 16;

   localparam int DIMS     = 3;
   localparam int SCORE_W  = 19;
   localparam int TP_W     = 4;
   localparam int EP_W     = 16;
   localparam int PAD_W    = 16;
   localparam int MODE_W   = 6;
   localparam int ACT_W    = 3;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 19;
   localparam int RSP_FLAG_W = 3;

   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

   // Register values after reset.
   localparam int RST_DEACTIVATE = 1228;
   localparam int RST_ACTIVATE   = 2867;
   localparam int RST_PEAK_TOL   = 410;
   localparam int RST_TRANS_PTS  = 1;
   localparam int RST_EXTREME_PTS = 4096;
   localparam int RST_MIN_SCORE  = 4096;
   localparam int RST_EDGE_PAD   = 0;
   localparam int RST_MODE       = 3;

   typedef enum logic [CSR_AW-1:0] {
      CSR_DEACTIVATE,
      CSR_ACTIVATE,
      CSR_PEAK_TOL,
      CSR_TRANS_PTS,
      CSR_EXTREME_PTS,
      CSR_MIN_SCORE,
      CSR_EDGE_PAD,
      CSR_MODE
   } csr_addr_type;

   // Same bit layout as the mode register, highest field first.
   typedef struct packed {
      logic [ACT_W-1:0] base_action;
      logic             selected;
      logic             ext_en;
      logic             trans_en;
   } mode_type;

endpackage

FILE: src/efs_track.sv
// Peak and valley tracker for one effort dimension.
module efs_track
   import efs_pkg::*;
#(
   parameter int VAL_W = FRAC_BITS_DEF + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             reinit,    // frame offset zero, request moving on
   input  logic             step,      // processed frame with tracking enabled
   input  logic [VAL_W-1:0] value,
   input  logic [VAL_W-1:0] tolerance,
   output logic             hit
);

   logic [VAL_W-1:0] max_ff, max_in;
   logic [VAL_W-1:0] min_ff, min_in;
   logic             seek_ff, seek_in;

   logic [VAL_W-1:0] cur_max, cur_min, upd_max, upd_min;
   logic             cur_seek;
   logic [VAL_W:0]   val_plus_tol, min_plus_tol;

   always_comb begin
      cur_max  = reinit ? value : max_ff;
      cur_min  = reinit ? value : min_ff;
      cur_seek = reinit ? 1'b0 : seek_ff;

      upd_max = (value > cur_max) ? value : cur_max;
      upd_min = (value < cur_min) ? value : cur_min;

      // v < max - tol is tested as v + tol < max to stay unsigned.
      val_plus_tol = {1'b0, value} + {1'b0, tolerance};
      min_plus_tol = {1'b0, upd_min} + {1'b0, tolerance};

      hit = 1'b0;
      max_in  = cur_max;
      min_in  = cur_min;
      seek_in = cur_seek;
      if (step) begin
         max_in = upd_max;
         min_in = upd_min;
         if (cur_seek) begin
            if (val_plus_tol < {1'b0, upd_max}) begin
               hit     = 1'b1;
               min_in  = value;
               seek_in = 1'b0;
            end
         end else begin
            if ({1'b0, value} > min_plus_tol) begin
               hit     = 1'b1;
               max_in  = value;
               seek_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff  <= '0;
         min_ff  <= '0;
         seek_ff <= 1'b0;
      end else if (reinit || step) begin
         max_ff  <= max_in;
         min_ff  <= min_in;
         seek_ff <= seek_in;
      end
   end

endmodule

FILE: src/efs_score.sv
// Intensity, hysteresis flags, bonuses, saturation and key decisions for one frame.
module efs_score
   import efs_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int VAL_W     = FRAC_BITS + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      reinit,
   input  logic                      processed,
   input  logic                      is_manual,
   input  logic [DIMS-1:0][VAL_W-1:0] value,
   input  logic [DIMS-1:0]           hits,
   input  mode_type                  mode,
   input  logic [VAL_W-1:0]          activate_level,
   input  logic [VAL_W-1:0]          deactivate_level,
   input  logic [TP_W-1:0]           transition_points,
   input  logic [EP_W-1:0]           extremity_points,
   input  logic [SCORE_W-1:0]        min_score,
   output logic [SCORE_W-1:0]        frame_score,
   output logic                      contributes,
   output logic                      is_key,
   output logic [ACT_W-1:0]          action_code
);

   localparam int SUM_W = (FRAC_BITS > 12) ? FRAC_BITS + 8 : 21;
   localparam logic [VAL_W-1:0] HALF_VAL = VAL_W'(1 << (FRAC_BITS - 1));

   logic [ACT_W-1:0]  flags_ff, flags_in;
   logic [ACT_W-1:0]  cur_flags, next_flags, flips;
   logic [1:0]        flip_count;
   logic [5:0]        trans_units;
   logic [VAL_W-1:0]  diff;
   logic [SUM_W-1:0]  intensity, trans_bonus, ext_bonus, total;
   logic              do_trans, above;

   always_comb begin
      cur_flags = reinit ? mode.base_action : flags_ff;
      do_trans  = processed && mode.trans_en;

      intensity  = '0;
      ext_bonus  = '0;
      next_flags = cur_flags;
      for (int d = 0; d < DIMS; d++) begin
         diff = (value[d] > HALF_VAL) ? value[d] - HALF_VAL : HALF_VAL - value[d];
         intensity = intensity + SUM_W'({diff, 1'b0});
         // Space drives the top flag bit, time the bottom one.
         if (!cur_flags[DIMS-1-d] && value[d] > activate_level) begin
            next_flags[DIMS-1-d] = 1'b1;
         end else if (cur_flags[DIMS-1-d] && value[d] < deactivate_level) begin
            next_flags[DIMS-1-d] = 1'b0;
         end
         if (mode.ext_en && hits[d]) begin
            ext_bonus = ext_bonus + SUM_W'(extremity_points);
         end
      end

      flips       = next_flags ^ cur_flags;
      flip_count  = 2'($countones(flips));
      trans_units = {4'b0000, flip_count} * {2'b00, transition_points};
      trans_bonus = mode.trans_en ? (SUM_W'(trans_units) << FRAC_BITS) : '0;
      flags_in    = do_trans ? next_flags : cur_flags;

      total = intensity + trans_bonus + ext_bonus;
      if (!processed) begin
         frame_score = '0;
      end else if (total > SUM_W'(SCORE_MAX)) begin
         frame_score = SCORE_MAX;
      end else begin
         frame_score = total[SCORE_W-1:0];
      end

      above = frame_score > min_score;
      if (!processed) begin
         contributes = 1'b0;
         is_key      = 1'b0;
      end else if (mode.selected) begin
         contributes = above && is_manual;
         is_key      = is_manual;
      end else begin
         contributes = above;
         is_key      = above || is_manual;
      end
      action_code = flags_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= ACT_W'(RST_MODE >> 3);
      end else if (advance) begin
         flags_ff <= flags_in;
      end
   end

endmodule

FILE: src/effort_frame_scorer_core.sv
// Top level of the effort frame scorer: registers, request and response stages.
//
// Each request carries three effort values, the frame offset, the frames left to the end
// of the range and a manual flag; each one yields exactly one response with the frame
// score, the processed/contributes/key flags and the effort action after the frame. The
// block takes one request per clock unless rsp_tready holds back the response register.
// The request is registered, scored in one pass and registered again on the response
// side. One request per clock is held by the registered feedback of the hysteresis flags
// and the peak trackers into the scoring logic. The user must write the registers through
// the csr_ port only while no request is in flight; the block itself does not enforce it.
// After reset the block is ready at once.
module effort_frame_scorer_core
   import efs_pkg::*;
#(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF,
   parameter int VAL_W       = FRAC_BITS + 1,
   parameter int REQ_W       = ((DIMS * VAL_W + 2 * OFFSET_BITS + 7) / 8) * 8,
   parameter int RSP_W       = ((OFFSET_BITS + SCORE_W + ACT_W + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata from bit 0: effort_space, effort_weight, effort_time, frame_offset,
   // frames_to_end, zero fill
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,
   // req_tuser: is_manual
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata from bit 0: frame_offset_out, frame_score, action_code, zero fill
   output logic [RSP_W-1:0]      rsp_tdata,
   // rsp_tuser from bit 0: processed, contributes, is_key
   output logic [RSP_FLAG_W-1:0] rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_AW-1:0]     csr_addr,
   input  logic [CSR_DW-1:0]     csr_wdata
);

   localparam int CMP_W = (OFFSET_BITS > PAD_W) ? OFFSET_BITS : PAD_W;

   // Configuration registers.
   logic [VAL_W-1:0]   deact_ff, act_ff, tol_ff;
   logic [TP_W-1:0]    tpts_ff;
   logic [EP_W-1:0]    epts_ff;
   logic [SCORE_W-1:0] min_score_ff;
   logic [PAD_W-1:0]   pad_ff;
   logic [MODE_W-1:0]  mode_ff;
   mode_type           mode;

   always_ff @(posedge clock) begin
      if (reset) begin
         deact_ff     <= VAL_W'(RST_DEACTIVATE);
         act_ff       <= VAL_W'(RST_ACTIVATE);
         tol_ff       <= VAL_W'(RST_PEAK_TOL);
         tpts_ff      <= TP_W'(RST_TRANS_PTS);
         epts_ff      <= EP_W'(RST_EXTREME_PTS);
         min_score_ff <= SCORE_W'(RST_MIN_SCORE);
         pad_ff       <= PAD_W'(RST_EDGE_PAD);
         mode_ff      <= MODE_W'(RST_MODE);
      end else if (csr_we) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_DEACTIVATE:  deact_ff     <= csr_wdata[VAL_W-1:0];
            CSR_ACTIVATE:    act_ff       <= csr_wdata[VAL_W-1:0];
            CSR_PEAK_TOL:    tol_ff       <= csr_wdata[VAL_W-1:0];
            CSR_TRANS_PTS:   tpts_ff      <= csr_wdata[TP_W-1:0];
            CSR_EXTREME_PTS: epts_ff      <= csr_wdata[EP_W-1:0];
            CSR_MIN_SCORE:   min_score_ff <= csr_wdata[SCORE_W-1:0];
            CSR_EDGE_PAD:    pad_ff       <= csr_wdata[PAD_W-1:0];
            CSR_MODE:        mode_ff      <= csr_wdata[MODE_W-1:0];
         endcase
      end
   end

   assign mode = mode_type'(mode_ff);

   // Request stage.
   logic                             req_valid_ff;
   logic [DIMS-1:0][VAL_W-1:0]       val_ff;
   logic [OFFSET_BITS-1:0]           offset_ff, to_end_ff;
   logic                             manual_ff;
   logic                             advance, req_take;

   assign advance    = req_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         for (int d = 0; d < DIMS; d++) begin
            val_ff[d] <= req_tdata[d*VAL_W +: VAL_W];
         end
         offset_ff <= req_tdata[DIMS*VAL_W +: OFFSET_BITS];
         to_end_ff <= req_tdata[DIMS*VAL_W+OFFSET_BITS +: OFFSET_BITS];
         manual_ff <= req_tuser;
      end
   end

   // Scoring pass.
   logic                   reinit, processed;
   logic [DIMS-1:0]        hits;
   logic [SCORE_W-1:0]     frame_score;
   logic                   contributes, is_key;
   logic [ACT_W-1:0]       action_code;

   assign reinit    = advance && (offset_ff == '0);
   assign processed = mode.selected ||
                      (CMP_W'(offset_ff) > CMP_W'(pad_ff) &&
                       CMP_W'(to_end_ff) > CMP_W'(pad_ff));

   for (genvar g = 0; g < DIMS; g++) begin : g_track
      efs_track #(
         .VAL_W(VAL_W)
      ) u_track (
         .clock    (clock),
         .reset    (reset),
         .reinit   (reinit),
         .step     (advance && processed && mode.ext_en),
         .value    (val_ff[g]),
         .tolerance(tol_ff),
         .hit      (hits[g])
      );
   end

   efs_score #(
      .FRAC_BITS(FRAC_BITS),
      .VAL_W    (VAL_W)
   ) u_score (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .reinit           (offset_ff == '0),
      .processed        (processed),
      .is_manual        (manual_ff),
      .value            (val_ff),
      .hits             (hits),
      .mode             (mode),
      .activate_level   (act_ff),
      .deactivate_level (deact_ff),
      .transition_points(tpts_ff),
      .extremity_points (epts_ff),
      .min_score        (min_score_ff),
      .frame_score      (frame_score),
      .contributes      (contributes),
      .is_key           (is_key),
      .action_code      (action_code)
   );

   // Response stage.
   logic                   rsp_valid_ff;
   logic [OFFSET_BITS-1:0] rsp_offset_ff;
   logic [SCORE_W-1:0]     rsp_score_ff;
   logic [ACT_W-1:0]       rsp_action_ff;
   logic [RSP_FLAG_W-1:0]  rsp_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_offset_ff <= offset_ff;
         rsp_score_ff  <= frame_score;
         rsp_action_ff <= action_code;
         rsp_flags_ff  <= {is_key, contributes, processed};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_action_ff, rsp_score_ff, rsp_offset_ff});
   assign rsp_tuser  = rsp_flags_ff;

endmodule
